// ===== rtl/core/bba_pkg.sv =====
// bba_pkg: shared constants, payload words, controller states and the command and status
// structs for the power-of-two buffer allocator
// no dependencies
package bba_pkg;

  localparam int POOL_PAGES      = 4096;
  localparam int MAX_SEGMENTS    = 10;
  localparam int NUM_CLASSES     = 9;
  localparam int MIN_BLOCK_ORDER = 12;

  localparam int STORE_DEPTH = 2 * POOL_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int CNT_W       = $clog2(POOL_PAGES) + 1;
  localparam int SEG_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int OFF_W       = 12;
  localparam int REQ_W       = 32;
  localparam int SIZE_W      = 21;
  localparam int TOTAL_W     = 24;
  localparam int CFG_W       = 13;
  localparam int ORD_W       = $clog2(SIZE_W);

  typedef logic [CLS_W-1:0] cls_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // opcodes and result status codes
  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  free_offset_pages;
    logic [SIZE_W-1:0] free_size_bytes;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [OFF_W-1:0]   seg_offset_pages;
    logic [SIZE_W-1:0]  seg_bytes;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_CLS, S_REB, S_SRCH, S_UPRD, S_SPLIT, S_FOUND, S_POP, S_GRANT, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic do_free;
    logic calc_cls;
    logic reb_check;
    logic pop_up;
    logic latch_blk;
    logic split;
    logic pop_c;
    logic grant;
    logic fail_mark;
    logic finish;
  } bba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic can_alloc;
    logic seg_done;
    logic cls_nz;
    logic up_found;
    logic split_last;
    logic grant_ok;
    logic out_free;
  } bba_stat_t;

  // start of a class's stack region: sum of POOL_PAGES >> j for j below c
  function automatic logic [ADDR_W-1:0] region_base(cls_t c);
    return ADDR_W'(STORE_DEPTH - (STORE_DEPTH >> c));
  endfunction

  // stack capacity of a class
  function automatic cnt_t class_cap(cls_t c);
    return CNT_W'(POOL_PAGES >> c);
  endfunction

endpackage

// ===== rtl/core/bba_ctrl.sv =====
// bba_ctrl: sequencing state machine of the buffer allocator
// depends on bba_pkg; drives bba_datapath through bba_cmd_t commands
module bba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.is_free) begin
            state_next = S_FREE;
          end else if (stat.can_alloc) begin
            state_next = S_CLS;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FREE: begin
        if (stat.out_free) begin
          cmd.do_free = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_CLS: begin
        if (stat.seg_done) begin
          state_next = S_DONE;
        end else begin
          cmd.calc_cls = 1'b1;
          state_next   = S_REB;
        end
      end
      S_REB: begin
        cmd.reb_check = 1'b1;
        state_next    = S_SRCH;
      end
      S_SRCH: begin
        if (stat.cls_nz) begin
          state_next = S_POP;
        end else if (stat.up_found) begin
          cmd.pop_up = 1'b1;
          state_next = S_UPRD;
        end else begin
          cmd.fail_mark = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_UPRD: begin
        cmd.latch_blk = 1'b1;
        state_next    = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        if (stat.split_last) begin
          state_next = S_FOUND;
        end
      end
      S_FOUND: begin
        if (stat.cls_nz) begin
          state_next = S_POP;
        end else begin
          cmd.fail_mark = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_POP: begin
        cmd.pop_c  = 1'b1;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        if (stat.grant_ok) begin
          cmd.grant  = 1'b1;
          state_next = S_CLS;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bba_datapath.sv =====
// bba_datapath: free-block stack memory, per-class counts, pool bookkeeping and result words
// depends on bba_pkg; commanded by bba_ctrl
module bba_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  bba_pkg::in_word_t        in_word,
  output bba_pkg::out_word_t       out_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     cfg_we,
  input  logic [bba_pkg::CFG_W-1:0] cfg_data,
  input  bba_pkg::bba_cmd_t        cmd,
  output bba_pkg::bba_stat_t       stat
);
  import bba_pkg::*;

  // stack store, one region per class
  logic [OFF_W-1:0] mem [STORE_DEPTH];
  logic [OFF_W-1:0] mem_q;

  cnt_t             pool;
  cls_t             top;
  cnt_t             allocated;
  logic             susp;
  cnt_t             counts [NUM_CLASSES];
  cnt_t             wm;
  in_word_t         req;
  logic [REQ_W-1:0] left;
  logic [TOTAL_W-1:0] total;
  logic [SEG_W-1:0] nseg;
  cls_t             cls;
  cls_t             cur;
  logic [OFF_W-1:0] blk;
  out_word_t        pend;
  logic             pend_v;
  logic             rd_virt;
  logic [OFF_W-1:0] rd_vval;

  logic [OFF_W-1:0] pop_data;
  cnt_t             cfg_pool;
  cnt_t             reb_p;
  cls_t             reb_top;
  cnt_t             reb_n;
  logic             reb_go;
  cls_t             calc_c;
  logic             up_found;
  cls_t             up_cls;
  logic             pop_en;
  cls_t             pop_cls;
  cnt_t             pop_idx;
  logic             pop_virt;
  logic             push_en;
  cls_t             push_cls;
  logic [OFF_W-1:0] push_val;
  logic             push_do;
  logic [ORD_W-1:0] forder;
  logic             f_ok;
  cls_t             fc;
  cnt_t             f_pages;
  logic             f_accept;
  cnt_t             f_alloc;
  logic [SIZE_W-1:0] g_bytes;
  logic             out_free;
  out_word_t        g_word;

  assign pop_data = rd_virt ? rd_vval : mem_q;
  assign out_free = !out_valid || out_ready;

  // pool size clamp for a configuration write
  always_comb begin
    if (cfg_data == '0) begin
      cfg_pool = CNT_W'(1);
    end else if (cfg_data > CFG_W'(POOL_PAGES)) begin
      cfg_pool = CNT_W'(POOL_PAGES);
    end else begin
      cfg_pool = CNT_W'(cfg_data);
    end
  end

  // rebuild target: largest usable class and its block count
  always_comb begin
    if (rst) begin
      reb_p = CNT_W'(POOL_PAGES);
    end else if (cfg_we) begin
      reb_p = cfg_pool;
    end else begin
      reb_p = pool;
    end
    reb_top = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (reb_p[i]) begin
        reb_top = (i > NUM_CLASSES - 1) ? cls_t'(NUM_CLASSES - 1) : cls_t'(i);
      end
    end
    reb_n = reb_p >> reb_top;
  end

  // size class for the bytes still wanted, clamped to the active classes
  always_comb begin
    calc_c = '0;
    for (int j = 0; j < NUM_CLASSES - 1; j++) begin
      if (cls_t'(j) < top && left > (REQ_W'(1) << (MIN_BLOCK_ORDER + j))) begin
        calc_c = calc_c + cls_t'(1);
      end
    end
  end

  // nearest larger class with a free block
  always_comb begin
    up_found = 1'b0;
    up_cls   = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (cls_t'(i) > cls && cls_t'(i) <= top && counts[i] != '0) begin
        up_found = 1'b1;
        up_cls   = cls_t'(i);
      end
    end
  end

  // pop port: entries of the rebuilt class below the low-water mark are implied
  assign pop_en   = cmd.pop_up || cmd.pop_c;
  assign pop_cls  = cmd.pop_up ? up_cls : cls;
  assign pop_idx  = counts[pop_cls] - CNT_W'(1);
  assign pop_virt = (pop_cls == top) && (pop_idx < wm);

  // free request decode
  always_comb begin
    forder = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (req.free_size_bytes[i]) begin
        forder = ORD_W'(i);
      end
    end
    fc      = cls_t'(forder - ORD_W'(MIN_BLOCK_ORDER));
    f_pages = CNT_W'(1) << fc;
    f_ok    = (req.free_size_bytes != '0) && (forder >= ORD_W'(MIN_BLOCK_ORDER)) &&
              (fc <= top) && ((CNT_W'(req.free_offset_pages) + f_pages) <= pool);
    f_alloc = (allocated > f_pages) ? (allocated - f_pages) : '0;
  end

  // push port: split halves or a freed segment
  always_comb begin
    push_en  = cmd.split || (cmd.do_free && f_ok);
    push_cls = fc;
    push_val = req.free_offset_pages;
    if (cmd.split) begin
      if (cur > cls) begin
        push_cls = cur - cls_t'(1);
        push_val = blk + (OFF_W'(1) << (cur - cls_t'(1)));
      end else begin
        push_cls = cls;
        push_val = blk;
      end
    end
    push_do = push_en && (counts[push_cls] < class_cap(push_cls));
  end

  assign f_accept = cmd.do_free && f_ok && push_do;
  assign reb_go   = (cmd.reb_check && allocated == '0 && counts[cls] == '0) ||
                    (f_accept && f_alloc == '0 && susp);

  // stack memory
  always_ff @(posedge clk) begin
    if (push_do) begin
      mem[region_base(push_cls) + ADDR_W'(counts[push_cls])] <= push_val;
    end
    if (pop_en) begin
      mem_q <= mem[region_base(pop_cls) + ADDR_W'(pop_idx)];
    end
  end

  // class counts, low-water mark, active top class, pool bookkeeping
  always_ff @(posedge clk) begin
    if (rst || cfg_we || reb_go) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= (cls_t'(i) == reb_top) ? reb_n : '0;
      end
      wm  <= reb_n;
      top <= reb_top;
    end else begin
      if (pop_en) begin
        counts[pop_cls] <= pop_idx;
        if (pop_virt) begin
          wm <= pop_idx;
        end
      end
      if (push_do) begin
        counts[push_cls] <= counts[push_cls] + CNT_W'(1);
      end
    end
    if (rst || cfg_we) begin
      pool      <= reb_p;
      allocated <= '0;
      susp      <= 1'b0;
    end else begin
      if (f_accept) begin
        allocated <= f_alloc;
        if (f_alloc == '0) begin
          susp <= 1'b0;
        end
      end
      if (cmd.grant) begin
        allocated <= allocated + (CNT_W'(1) << cls);
      end
      if (cmd.fail_mark && cls != '0) begin
        susp <= 1'b1;
      end
    end
  end

  // request working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= in_word;
      left  <= in_word.request_bytes;
      total <= '0;
      nseg  <= '0;
    end
    if (cmd.calc_cls) begin
      cls <= calc_c;
    end
    if (cmd.pop_up) begin
      cur <= up_cls;
    end
    if (pop_en) begin
      rd_virt <= pop_virt;
      rd_vval <= OFF_W'(pop_idx << pop_cls);
    end
    if (cmd.latch_blk) begin
      blk <= pop_data;
    end
    if (cmd.split && cur > cls) begin
      cur <= cur - cls_t'(1);
    end
    if (cmd.grant) begin
      left  <= (left > REQ_W'(g_bytes)) ? (left - REQ_W'(g_bytes)) : '0;
      total <= total + TOTAL_W'(g_bytes);
      nseg  <= nseg + SEG_W'(1);
    end
  end

  // granted segment word
  always_comb begin
    g_bytes                 = SIZE_W'(1) << (MIN_BLOCK_ORDER + int'(cls));
    g_word.status           = ST_GRANT;
    g_word.seg_offset_pages = pop_data;
    g_word.seg_bytes        = g_bytes;
    g_word.total_bytes      = total + TOTAL_W'(g_bytes);
    g_word.last             = 1'b0;
  end

  // pending segment and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else begin
      out_valid <= (out_valid && !out_ready) || cmd.do_free || (cmd.grant && pend_v) ||
                   cmd.finish;
      if (cmd.load) begin
        pend_v <= 1'b0;
      end
      if (cmd.do_free) begin
        out_word <= '{status: ST_FREED, seg_offset_pages: '0, seg_bytes: '0,
                      total_bytes: '0, last: 1'b1};
      end
      if (cmd.grant) begin
        if (pend_v) begin
          out_word <= pend;
        end
        pend   <= g_word;
        pend_v <= 1'b1;
      end
      if (cmd.finish) begin
        if (pend_v) begin
          out_word <= '{status: pend.status, seg_offset_pages: pend.seg_offset_pages,
                        seg_bytes: pend.seg_bytes, total_bytes: pend.total_bytes,
                        last: 1'b1};
        end else begin
          out_word <= '{status: ST_NOMEM, seg_offset_pages: '0, seg_bytes: '0,
                        total_bytes: '0, last: 1'b1};
        end
        pend_v <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    stat.is_free    = (in_word.opcode == OP_FREE);
    stat.can_alloc  = (allocated < pool) && !susp;
    stat.seg_done   = (nseg == SEG_W'(MAX_SEGMENTS)) || (left == '0);
    stat.cls_nz     = (counts[cls] != '0);
    stat.up_found   = up_found;
    stat.split_last = (cur == cls);
    stat.grant_ok   = !pend_v || out_free;
    stat.out_free   = out_free;
  end

endmodule

// ===== rtl/core/pow2_bin_buffer_allocator_unit.sv =====
// pow2_bin_buffer_allocator_unit: top level of the power-of-two buffer pool allocator
// depends on bba_pkg, bba_ctrl and bba_datapath
//
// Buffer pool allocator with power-of-two size classes of 4 KiB up to 1 MiB, each class
// holding a stack of free block offsets in one store with a single push port and a single
// pop port. An allocate word grants segments one after another; a segment whose class is
// empty is cut from the nearest larger free block, which is halved down one class level at a
// time, and a search that finds nothing ends with the closing word. A request refused at once
// (pool full or suspended) gets a no-memory closing word. A result side that is not ready
// stalls the sequence. Pool rebuilds (after reset, a pool_pages write, or, with the pool
// wholly free, when a request finds its class empty or a free ends a suspension) take effect
// at once: the rebuilt top-class stack is implied by a low-water mark, so there is no
// clearing pass.
// A finished result may wait in the output register while the next word is accepted.
module pow2_bin_buffer_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bba_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bba_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [bba_pkg::CFG_W-1:0] cfg_data
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // sequencer
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stacks and bookkeeping
  bba_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the power-of-two buffer pool allocator
// depends on bba_pkg and pow2_bin_buffer_allocator_unit
`timescale 1ns / 100ps

// scoreboard: keeps its own copy of the allocator state and the expected result words
class alloc_scoreboard;
  bba_pkg::out_word_t pending_words[$];
  int                 errors;
  int                 checked;
  int                 grants;
  int                 nomems;
  logic [11:0]        bin_store[9][$];
  int unsigned        pool_cfg;
  int unsigned        top_classes;
  int unsigned        used_pages;
  bit                 suspended;

  function new();
    errors = 0;
    checked = 0;
    grants = 0;
    nomems = 0;
    set_pool(4096);
  endfunction

  function int unsigned pool_size();
    int unsigned p;
    p = pool_cfg;
    if (p < 1) p = 1;
    if (p > bba_pkg::POOL_PAGES) p = bba_pkg::POOL_PAGES;
    return p;
  endfunction

  function bit push_blk(int unsigned c, int unsigned off);
    if (c >= bba_pkg::NUM_CLASSES) return 0;
    if (bin_store[c].size() >= (bba_pkg::POOL_PAGES >> c)) return 0;
    bin_store[c].push_back(off[11:0]);
    return 1;
  endfunction

  // put the whole pool back into the largest usable class
  function void refill_bins();
    int unsigned p;
    p = pool_size();
    for (int c = 0; c < bba_pkg::NUM_CLASSES; c++) bin_store[c].delete();
    for (int c = 0; c < bba_pkg::NUM_CLASSES; c++) begin
      if (c == bba_pkg::NUM_CLASSES - 1 || (2 << c) > p) begin
        for (int k = 0; k < (p >> c); k++) void'(push_blk(c, k << c));
        top_classes = c + 1;
        return;
      end
    end
  endfunction

  function void set_pool(int unsigned v);
    pool_cfg = v;
    top_classes = bba_pkg::NUM_CLASSES;
    used_pages = 0;
    suspended = 0;
    refill_bins();
  endfunction

  function bit take_blk(longint unsigned left, output int unsigned off,
                        output int unsigned c);
    int unsigned o;
    int unsigned hi;
    int unsigned b;
    int          cur;
    o = 0;
    off = 0;
    c = 0;
    while (o < 63 && (64'd1 << o) < left) o++;
    hi = bba_pkg::MIN_BLOCK_ORDER + top_classes - 1;
    if (o < bba_pkg::MIN_BLOCK_ORDER) o = bba_pkg::MIN_BLOCK_ORDER;
    if (o > hi) o = hi;
    c = o - bba_pkg::MIN_BLOCK_ORDER;
    if (used_pages == 0 && bin_store[c].size() == 0) refill_bins();
    // split the nearest larger block down
    if (bin_store[c].size() == 0) begin
      for (cur = c + 1; cur < top_classes; cur++) begin
        if (bin_store[cur].size() != 0) begin
          b = bin_store[cur].pop_back();
          while (cur > c) begin
            cur--;
            void'(push_blk(cur, b + (1 << cur)));
          end
          void'(push_blk(c, b));
          break;
        end
      end
    end
    if (bin_store[c].size() == 0) begin
      if (c > 0) suspended = 1;
      return 0;
    end
    off = bin_store[c].pop_back();
    used_pages += 1 << c;
    return 1;
  endfunction

  function void note_word(bba_pkg::in_word_t w);
    bba_pkg::out_word_t r;
    longint unsigned    left;
    longint unsigned    total;
    longint unsigned    bytes;
    int unsigned        off;
    int unsigned        c;
    int unsigned        ord;
    int unsigned        pages;
    int                 n;
    if (w.opcode == bba_pkg::OP_FREE) begin
      if (w.free_size_bytes != 0) begin
        ord = 0;
        while (ord < 31 && (w.free_size_bytes >> (ord + 1)) != 0) ord++;
        if (ord >= bba_pkg::MIN_BLOCK_ORDER) begin
          c = ord - bba_pkg::MIN_BLOCK_ORDER;
          pages = 1 << c;
          if (c < top_classes && w.free_offset_pages + pages <= pool_size()) begin
            if (push_blk(c, w.free_offset_pages)) begin
              used_pages -= (pages < used_pages) ? pages : used_pages;
              if (used_pages == 0 && suspended) begin
                refill_bins();
                suspended = 0;
              end
            end
          end
        end
      end
      r = '0;
      r.status = bba_pkg::ST_FREED;
      r.last = 1'b1;
      pending_words.push_back(r);
      return;
    end
    left = w.request_bytes;
    total = 0;
    n = 0;
    if (used_pages < pool_size() && !suspended) begin
      while (n < bba_pkg::MAX_SEGMENTS && left != 0) begin
        if (!take_blk(left, off, c)) break;
        bytes = 64'd1 << (bba_pkg::MIN_BLOCK_ORDER + c);
        left -= (bytes < left) ? bytes : left;
        total += bytes;
        r = '0;
        r.status = bba_pkg::ST_GRANT;
        r.seg_offset_pages = off[11:0];
        r.seg_bytes = bytes[20:0];
        r.total_bytes = total[23:0];
        pending_words.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      r.status = bba_pkg::ST_NOMEM;
      r.last = 1'b1;
      pending_words.push_back(r);
      nomems++;
    end else begin
      pending_words[pending_words.size() - 1].last = 1'b1;
      grants += n;
    end
  endfunction

  function void report(string what, bba_pkg::out_word_t got, bba_pkg::out_word_t want);
    $display("mismatch %0s: got %h want %h", what, got, want);
    errors++;
  endfunction

  function void check_word(bba_pkg::out_word_t got);
    bba_pkg::out_word_t want;
    checked++;
    if (pending_words.size() == 0) begin
      report("unexpected word", got, '0);
      return;
    end
    want = pending_words.pop_front();
    if (got.status != want.status) report("status", got, want);
    if (got.seg_offset_pages != want.seg_offset_pages) report("offset", got, want);
    if (got.seg_bytes != want.seg_bytes) report("seg_bytes", got, want);
    if (got.total_bytes != want.total_bytes) report("total_bytes", got, want);
    if (got.last != want.last) report("last", got, want);
  endfunction
endclass

module testbench;
  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  bba_pkg::in_word_t         in_word;
  logic                      out_valid;
  logic                      out_ready;
  bba_pkg::out_word_t        out_word;
  logic                      cfg_we;
  logic [bba_pkg::CFG_W-1:0] cfg_data;

  alloc_scoreboard sb;
  int unsigned     cycle_count;
  int              words_sent;
  int              rx_gap;
  int              rx_pick;
  // offsets and sizes of segments currently held, for realistic frees
  logic [11:0]     held_off[$];
  logic [20:0]     held_size[$];

  pow2_bin_buffer_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    sb = new();
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end
  initial cycle_count = 0;

  // receiving side: random stalls, result check on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_word(out_word);
      if (out_word.status == bba_pkg::ST_GRANT) begin
        held_off.push_back(out_word.seg_offset_pages);
        held_size.push_back(out_word.seg_bytes);
      end
      rx_pick = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) rx_pick = 0;
      out_ready <= (rx_pick == 0);
      rx_gap <= rx_pick;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= (rx_gap == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays up after an accepted word until the next word or an idle stretch
  task automatic send_word(bba_pkg::in_word_t w);
    int gap;
    gap = $urandom_range(0, 6);
    if (words_sent % 40 < 10) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send_alloc(logic [31:0] bytes);
    bba_pkg::in_word_t w;
    w = '0;
    w.opcode = bba_pkg::OP_ALLOC;
    w.request_bytes = bytes;
    w.free_offset_pages = 12'($urandom);
    w.free_size_bytes = 21'($urandom);
    send_word(w);
  endtask

  task automatic send_free(logic [11:0] off, logic [20:0] size);
    bba_pkg::in_word_t w;
    w = '0;
    w.opcode = bba_pkg::OP_FREE;
    w.request_bytes = $urandom;
    w.free_offset_pages = off;
    w.free_size_bytes = size;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // release every held segment
  task automatic free_all_held();
    while (held_off.size() != 0)
      send_free(held_off.pop_front(), held_size.pop_front());
  endtask

  task automatic write_pool(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_pool(v);
    held_off.delete();
    held_size.delete();
  endtask

  function automatic logic [31:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 4096);
      1: return $urandom_range(1, 65536);
      2: return $urandom_range(1, 1 << 20);
      3: return 32'd1 << $urandom_range(12, 20);
      4: return $urandom_range(1, 3 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int count);
    int idx;
    for (int i = 0; i < count; i++) begin
      if (held_off.size() != 0 && $urandom_range(0, 9) < 4) begin
        idx = $urandom_range(0, held_off.size() - 1);
        send_free(held_off[idx], held_size[idx]);
        held_off.delete(idx);
        held_size.delete(idx);
      end else if ($urandom_range(0, 19) == 0) begin
        // noise: arbitrary free fields
        send_free(12'($urandom), 21'($urandom));
      end else begin
        send_alloc(rand_bytes());
      end
    end
  endtask

  initial begin
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, splits, full pool, odd and ignored frees
    send_alloc(32'd1);
    send_alloc(32'd4096);
    send_alloc(32'd4097);
    send_alloc(32'd1 << 20);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'd0);
    send_free(12'd0, 21'd4096);
    send_free(12'd0, 21'd6000);
    send_free(12'hFFF, 21'h1F_FFFF);
    send_free(12'd0, 21'd0);
    send_free(12'd8, 21'd2048);
    send_free(12'd4095, 21'd8192);
    send_free(12'd100, 21'h10_0000);
    free_all_held();
    send_alloc(32'd3 << 20);
    send_alloc(32'd12345);
    drain();
    // sender holds off until every result is in
    free_all_held();
    drain();

    write_pool(1);
    send_alloc(32'd1 << 20);
    send_alloc(32'd4096);
    free_all_held();
    send_alloc(32'd8192);
    write_pool(0);
    send_alloc(32'd100);
    send_free(12'd0, 21'd4096);
    write_pool(8191);
    random_phase(120);
    write_pool(37);
    random_phase(60);
    write_pool(700);
    random_phase(80);
    write_pool(4096);
    random_phase(100);
    drain();

    $display("covered %0d input words, %0d granted segments, %0d no-memory answers",
             words_sent, sb.grants, sb.nomems);
    $display("pool sizes 0, 1, 37, 700, 4096 and 8191 with random stalls on both sides");
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_datapath.sv
rtl/core/pow2_bin_buffer_allocator_unit.sv
tb/testbench.sv
